[rtl/inl_pkg.sv]
// Shared types, constants and build-time table functions for the inverse normal lookup.
// Used by inl_rom, inl_div and inverse_normal_table_lookup; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package inl_pkg;

	localparam int DEF_TABLE_DEPTH  = 512;
	localparam int DEF_ENTRY_BITS   = 24;
	localparam int DEF_COUNT_BITS   = 16;

	localparam int RANK_BITS        = 25;
	localparam int MAG_BITS         = 24;
	localparam int DEV_BITS         = 24;
	localparam int QUO_BITS         = 24;
	localparam int STEP_BITS        = 5;
	localparam int PX_PRESHIFT      = 9;
	localparam int RANK_DIV_STEPS   = 24;
	localparam int INTERP_DIV_STEPS = 23;

	localparam logic [MAG_BITS-1:0] RANK_ONE = 24'h800000;

	localparam logic [63:0] Q62_ONE       = 64'h4000_0000_0000_0000;
	localparam logic [63:0] SQRT_2PI_Q32  = 64'd3426888095;
	localparam int          SERIES_TERMS  = 200;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RANK,
		ST_START,
		ST_SEARCH,
		ST_CHECK,
		ST_LO,
		ST_HI,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} inl_state_t;

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[125:62];
	endfunction

	function automatic logic [63:0] pow_q62(input logic [63:0] base, input logic [63:0] e);
		logic [63:0] r;
		logic [63:0] bb;
		r  = Q62_ONE;
		bb = base;
		for (int k = 0; k < 32; k++) begin
			if (e[k])
				r = mul_q62(r, bb);
			bb = mul_q62(bb, bb);
		end
		return r;
	endfunction

	// long division: quotient in the upper half, remainder in the lower half
	function automatic logic [127:0] div_rem64(input logic [63:0] a, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], a[k]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[k] = 1'b1;
			end
		end
		return {q, r[63:0]};
	endfunction

	function automatic logic [63:0] mul_div(input logic [63:0] a, input logic [63:0] n,
		input logic [63:0] d);
		logic [127:0] qr1;
		logic [127:0] qr2;
		qr1 = div_rem64(a, d);
		qr2 = div_rem64(qr1[63:0] * n, d);
		return qr1[127:64] * n + qr2[127:64];
	endfunction

	// P(idx * 4 / (depth - 1)) in Q0.ebits, rounded half up and saturated
	function automatic logic [63:0] rom_entry(input int idx, input int depth, input int ebits);
		logic [63:0] span;
		logic [63:0] dsq;
		logic [63:0] term;
		logic [63:0] e1;
		logic [63:0] ix;
		logic [63:0] g;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] v;
		logic [63:0] mask;
		logic [127:0] qr;
		span = 64'(depth - 1);
		dsq  = span * span;
		term = Q62_ONE;
		e1   = Q62_ONE;
		ix   = 64'(idx);
		mask = (64'd1 << ebits) - 64'd1;
		for (int k = 1; k <= 6; k++) begin
			qr   = div_rem64(term, 64'(k) * dsq);
			term = qr[127:64];
			if (k % 2 == 1)
				e1 = e1 - term;
			else
				e1 = e1 + term;
		end
		if (idx == 0)
			return 64'd0;
		g   = pow_q62(e1, 64'd8 * ix * ix);
		t   = mul_div(g, 64'd4 * ix, span);
		sum = t;
		for (int n = 0; n < SERIES_TERMS; n++) begin
			if (t != 64'd0) begin
				t   = mul_div(t, 64'd16 * ix * ix, dsq * 64'(2 * n + 3));
				sum = sum + t;
			end
		end
		v = (sum >> 31) * SQRT_2PI_Q32;
		v = (v + (64'd1 << (62 - ebits))) >> (63 - ebits);
		return (v > mask) ? mask : v;
	endfunction

endpackage

`default_nettype wire

[rtl/inl_rom.sv]
// Probability table ROM with one registered read port.
// Contents built at elaboration by inl_pkg::rom_entry.
`timescale 1ns / 1ps
`default_nettype none

module inl_rom
	import inl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int ENTRY_BITS  = DEF_ENTRY_BITS,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic [AW-1:0]         addr,
	output logic [ENTRY_BITS-1:0] rd_q
);

	logic [ENTRY_BITS-1:0] rom_mem [TABLE_DEPTH];

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
		localparam logic [63:0] ENTRY = rom_entry(g, TABLE_DEPTH, ENTRY_BITS);
		assign rom_mem[g] = ENTRY[ENTRY_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= rom_mem[addr];
	end

endmodule

`default_nettype wire

[rtl/inl_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Starts from a remainder below the divisor; uses inl_pkg constants.
`timescale 1ns / 1ps
`default_nettype none

module inl_div
	import inl_pkg::*;
#(
	parameter int W  = 40,
	parameter int QW = QUO_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [STEP_BITS-1:0] steps,
	input  logic [W-1:0]         rem_init,
	input  logic [QW-1:0]        quo_init,
	input  logic [W-1:0]         divisor,
	output logic                 done,
	output logic [QW-1:0]        quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         div_q;
	logic [QW-1:0]        quo_q;
	logic [W:0]           rem_sh;
	logic [W:0]           rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign ge      = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_BITS'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_BITS'(1);
				if (cnt_q == STEP_BITS'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

[rtl/inverse_normal_table_lookup.sv]
// Top level: rank front end, table search sequencer, interpolation and output register.
// Instantiates inl_rom and inl_div; uses inl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One item is processed at a time. From acceptance to a valid result, an item passes
// through the table search, one ROM read per cycle over log2(TABLE_DEPTH)-1 steps plus three
// further reads, and the shared one-bit-per-cycle divider, which runs 24 steps for a rank
// computed from rank index and sample count and 23 steps for the interpolation fraction; a
// direct rank (tuser = 0) skips the rank division. Saturated ranks skip the rank division and
// a saturated interpolation skips the fraction division. The next item is accepted the cycle
// after the previous result is loaded into the output register; a result not taken holds the block.

module inverse_normal_table_lookup
	import inl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int ENTRY_BITS  = DEF_ENTRY_BITS,
	parameter int COUNT_BITS  = DEF_COUNT_BITS,
	localparam int S_DATA_W   = ((RANK_BITS + 2 * COUNT_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// frac_rank, rank_index, sample_count, zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	// cmd
	input  logic [0:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// deviate
	output logic [DEV_BITS-1:0] m_tdata
);

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int PW       = ENTRY_BITS + 1;
	localparam int PX_SHIFT = 32 - ENTRY_BITS;
	localparam int BW       = AW + ENTRY_BITS;
	localparam int TW       = BW + 1;
	localparam int SW       = BW + 2;
	localparam int DIV_W    = (COUNT_BITS > BW) ? COUNT_BITS : BW;

	inl_state_t state_q, state_d;

	logic [MAG_BITS-1:0]   mag_q;
	logic                  nonneg_q;
	logic                  positive_q;
	logic [AW-1:0]         i_q;
	logic [AW-1:0]         step_q;
	logic [ENTRY_BITS-1:0] lo_q;
	logic [BW-1:0]         base_q;
	logic [BW-1:0]         dd_q;
	logic                  flat_q;
	logic [TW-1:0]         total_q;
	logic [DEV_BITS-1:0]   dev_q;
	logic                  m_tvalid_q;
	logic [DEV_BITS-1:0]   m_tdata_q;

	logic [AW-1:0]         rom_addr;
	logic [ENTRY_BITS-1:0] rom_rd;

	logic                  div_start;
	logic [STEP_BITS-1:0]  div_steps;
	logic [DIV_W-1:0]      div_rem0;
	logic [QUO_BITS-1:0]   div_quo0;
	logic [DIV_W-1:0]      div_divisor;
	logic                  div_done;
	logic [QUO_BITS-1:0]   div_quo;
	logic [MAG_BITS-1:0]   div_round;
	logic [MAG_BITS:0]     div_inc;

	logic                  accept;
	logic                  out_load;

	// input decode
	logic                  in_cmd;
	logic [RANK_BITS-1:0]  in_frac;
	logic [COUNT_BITS-1:0] in_rank;
	logic [COUNT_BITS-1:0] in_cnt;
	logic [RANK_BITS-1:0]  frac_abs;
	logic [MAG_BITS-1:0]   mag_direct;
	logic [COUNT_BITS:0]   two_rank;
	logic [COUNT_BITS:0]   cnt_p1;
	logic                  pos_c;
	logic [COUNT_BITS:0]   nm;
	logic                  rank_sat;
	logic [MAG_BITS-1:0]   mag_sat;

	// search and interpolation
	logic [MAG_BITS+PX_PRESHIFT-1:0] mag_sh;
	logic [PW-1:0]         px;
	logic                  go_up;
	logic [AW-1:0]         i_next;
	logic                  dec;
	logic [AW-1:0]         i_fin;
	logic [AW-1:0]         i_m1;
	logic                  flat;
	logic [ENTRY_BITS-1:0] den;
	logic [BW-1:0]         prod_base;
	logic [BW-1:0]         prod_dd;
	logic [SW-1:0]         sum_u;
	logic                  over2;
	logic                  over1;
	logic [TW-1:0]         rem_pre;

	function automatic logic [DEV_BITS-1:0] finish_dev(input logic [MAG_BITS-1:0] xq,
		input logic pos);
		logic [MAG_BITS-1:0] lim;
		logic [MAG_BITS-1:0] xs;
		lim = pos ? RANK_ONE : RANK_ONE - MAG_BITS'(1);
		xs  = (xq > lim) ? lim : xq;
		return pos ? DEV_BITS'(0) - DEV_BITS'(xs) : DEV_BITS'(xs);
	endfunction

	assign in_cmd  = s_tuser[0];
	assign in_frac = s_tdata[RANK_BITS-1:0];
	assign in_rank = s_tdata[RANK_BITS +: COUNT_BITS];
	assign in_cnt  = s_tdata[RANK_BITS+COUNT_BITS +: COUNT_BITS];

	assign frac_abs   = in_frac[RANK_BITS-1] ? RANK_BITS'(0) - in_frac : in_frac;
	assign mag_direct = (frac_abs > RANK_BITS'(RANK_ONE)) ? RANK_ONE : frac_abs[MAG_BITS-1:0];

	assign two_rank = {in_rank, 1'b0};
	assign cnt_p1   = {1'b0, in_cnt} + (COUNT_BITS+1)'(1);
	assign pos_c    = cnt_p1 >= two_rank;
	assign nm       = pos_c ? cnt_p1 - two_rank : two_rank - cnt_p1;
	assign rank_sat = (in_cnt == '0) || (nm >= {1'b0, in_cnt});
	assign mag_sat  = ((in_cnt == '0) && (nm == '0)) ? '0 : RANK_ONE;

	assign mag_sh = {mag_q, {PX_PRESHIFT{1'b0}}};
	assign px     = PW'(mag_sh >> PX_SHIFT);

	assign go_up  = px > {1'b0, rom_rd};
	assign i_next = go_up ? i_q + step_q : i_q - step_q;
	assign dec    = (i_q > AW'(1)) && (px < {1'b0, rom_rd});
	assign i_fin  = dec ? i_q - AW'(1) : i_q;
	assign i_m1   = i_q - AW'(1);

	assign flat      = rom_rd <= lo_q;
	assign den       = flat ? '0 : rom_rd - lo_q;
	assign prod_base = BW'(i_m1) * BW'(den);
	assign prod_dd   = BW'(TABLE_DEPTH - 1) * BW'(den);

	assign sum_u   = SW'(base_q) + SW'(px) - SW'(lo_q);
	assign over2   = total_q >= {dd_q, 1'b0};
	assign over1   = total_q >= {1'b0, dd_q};
	assign rem_pre = over1 ? total_q - {1'b0, dd_q} : total_q;

	assign div_inc   = {1'b0, div_quo} + (MAG_BITS+1)'(1);
	assign div_round = div_inc[MAG_BITS:1];

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		rom_addr    = i_m1;
		div_start   = 1'b0;
		div_steps   = STEP_BITS'(INTERP_DIV_STEPS);
		div_rem0    = DIV_W'(rem_pre);
		div_quo0    = QUO_BITS'(over1);
		div_divisor = DIV_W'(dd_q);
		s_tready    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (!in_cmd || rank_sat) begin
						state_d = ST_START;
					end else begin
						div_start   = 1'b1;
						div_steps   = STEP_BITS'(RANK_DIV_STEPS);
						div_rem0    = DIV_W'(nm);
						div_quo0    = '0;
						div_divisor = DIV_W'(in_cnt);
						state_d     = ST_RANK;
					end
				end
			end
			ST_RANK: begin
				if (div_done)
					state_d = ST_START;
			end
			ST_START: begin
				rom_addr = AW'(TABLE_DEPTH / 2 - 1);
				state_d  = ST_SEARCH;
			end
			ST_SEARCH: begin
				rom_addr = i_next - AW'(1);
				if (step_q == AW'(1))
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				rom_addr = i_fin - AW'(1);
				state_d  = ST_LO;
			end
			ST_LO: begin
				rom_addr = i_q;
				state_d  = ST_HI;
			end
			ST_HI: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				if (over2) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!in_cmd) begin
						mag_q    <= mag_direct;
						nonneg_q <= !in_frac[RANK_BITS-1];
					end else begin
						mag_q    <= mag_sat;
						nonneg_q <= pos_c;
					end
				end
			end
			ST_RANK: begin
				if (div_done)
					mag_q <= div_round;
			end
			ST_START: begin
				positive_q <= nonneg_q && (mag_q != '0);
				i_q        <= AW'(TABLE_DEPTH / 2);
				step_q     <= AW'(TABLE_DEPTH / 4);
			end
			ST_SEARCH: begin
				i_q    <= i_next;
				step_q <= step_q >> 1;
			end
			ST_CHECK: begin
				i_q <= i_fin;
			end
			ST_LO: begin
				lo_q <= rom_rd;
			end
			ST_HI: begin
				flat_q <= flat;
				base_q <= flat ? BW'(i_m1) : prod_base;
				dd_q   <= flat ? BW'(TABLE_DEPTH - 1) : prod_dd;
			end
			ST_SUM: begin
				if (flat_q)
					total_q <= TW'(base_q);
				else
					total_q <= sum_u[SW-1] ? '0 : sum_u[TW-1:0];
			end
			ST_PREP: begin
				if (over2)
					dev_q <= finish_dev(RANK_ONE, positive_q);
			end
			ST_DIV: begin
				if (div_done)
					dev_q <= finish_dev(div_round, positive_q);
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= dev_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	inl_rom #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.rd_q (rom_rd)
	);

	inl_div #(
		.W  (DIV_W),
		.QW (QUO_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.rem_init (div_rem0),
		.quo_init (div_quo0),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo)
	);

	a_search_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (i_q != '0))
		else $error("search index reached zero");

	a_search_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> $onehot(step_q))
		else $error("search step is not a single bit");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_RANK || state_q == ST_DIV))
		else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
